[rtl/core/minv_pkg.sv]
// Package for the modular inverse unit: widths and defaults.
`timescale 1ns / 1ps
package minv_pkg;
  localparam int DEF_WIDTH = 64;
  localparam int IN_W      = 64;
  localparam int INV_W     = 63;
endpackage

[rtl/core/modular_inverse_unit.sv]
// Modular inverse by extended Euclid, top level and round sequencer.
//
//  channel | ports                          | transfer
//  input   | in_value, in_modulus           | start high while busy low
//  result  | out_inverse, out_found         | out_valid high for one cycle
//
// Each Euclid round runs on the shared bit-serial divider, followed by a
// test state; an item takes up to ~1.44*WIDTH rounds, and the unit is busy throughout.
// Special cases skip the rounds. Synchronous reset clears the sequencer.
// The receiver cannot stall: each result shows for one cycle only.
`timescale 1ns / 1ps
module modular_inverse_unit import minv_pkg::*; #(
  parameter int WIDTH = DEF_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [IN_W-1:0]  in_value,
  input  logic [IN_W-1:0]  in_modulus,
  output logic             out_valid,
  output logic [INV_W-1:0] out_inverse,
  output logic             out_found
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TEST = 2'd1;
  localparam logic [1:0] S_RUN  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [WIDTH-1:0] a_r, a_nxt, m_r, m_nxt, mm_r, mm_nxt, cur_r, cur_nxt, nx_r, nx_nxt;
  logic             odd_r, odd_nxt;
  logic             ov_r, ov_nxt, of_r, of_nxt;
  logic [WIDTH-1:0] oi_r, oi_nxt;
  logic [WIDTH-1:0] va, mo, res, rem, prod;
  logic             go, done;

  function automatic logic [WIDTH-1:0] mag(input logic [IN_W-1:0] raw);
    logic [WIDTH-1:0] v;
    v = raw[WIDTH-1:0];
    return v[WIDTH-1] ? WIDTH'(~v + 1'b1) : v;
  endfunction

  minv_div_step #(.WIDTH(WIDTH)) u_step (
    .clk(clk), .rst_n(rst_n), .go(go), .a(a_r), .m(m_r), .nxt(nx_r),
    .done(done), .rem(rem), .prod(prod)
  );

  always_comb begin
    va  = mag(in_value);
    mo  = mag(in_modulus);
    res = (odd_r && cur_r != '0) ? WIDTH'(mm_r - cur_r) : cur_r;
    state_nxt = state_r;
    a_nxt = a_r; m_nxt = m_r; mm_nxt = mm_r;
    cur_nxt = cur_r; nx_nxt = nx_r; odd_nxt = odd_r;
    ov_nxt = 1'b0; of_nxt = of_r; oi_nxt = oi_r;
    go = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          a_nxt = va; m_nxt = mo; mm_nxt = mo;
          cur_nxt = WIDTH'(1); nx_nxt = '0; odd_nxt = 1'b0;
          if (va == '0 || mo == '0 || mo == WIDTH'(1)) begin
            ov_nxt = 1'b1; of_nxt = 1'b0; oi_nxt = '0;
          end else begin
            state_nxt = S_TEST;
          end
        end
      end
      S_TEST: begin
        if (a_r > WIDTH'(1)) begin
          if (m_r == '0) begin
            ov_nxt = 1'b1; of_nxt = 1'b0; oi_nxt = '0;
            state_nxt = S_IDLE;
          end else begin
            go = 1'b1;
            state_nxt = S_RUN;
          end
        end else begin
          ov_nxt = 1'b1; of_nxt = 1'b1; oi_nxt = res;
          state_nxt = S_IDLE;
        end
      end
      S_RUN: begin
        if (done) begin
          a_nxt = m_r; m_nxt = rem;
          cur_nxt = nx_r; nx_nxt = cur_r + prod;
          odd_nxt = !odd_r;
          state_nxt = S_TEST;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    a_r <= a_nxt; m_r <= m_nxt; mm_r <= mm_nxt;
    cur_r <= cur_nxt; nx_r <= nx_nxt; odd_r <= odd_nxt;
    of_r <= of_nxt; oi_r <= oi_nxt;
  end

  assign busy        = state_r != S_IDLE;
  assign out_valid   = ov_r;
  assign out_found   = of_r;
  assign out_inverse = INV_W'(oi_r);
endmodule

[rtl/core/minv_div_step.sv]
// One Euclid round: bit-serial division a / m with running q * nxt product.
`timescale 1ns / 1ps
module minv_div_step import minv_pkg::*; #(
  parameter int WIDTH = DEF_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] m,
  input  logic [WIDTH-1:0] nxt,
  output logic             done,
  output logic [WIDTH-1:0] rem,
  output logic [WIDTH-1:0] prod
);
  localparam int CW = $clog2(WIDTH + 1);

  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [WIDTH-1:0] rem_r, rem_nxt, dvd_r, dvd_nxt, acc_r, acc_nxt;
  logic [WIDTH-1:0] m_r, m_nxt, n_r, n_nxt;
  logic [WIDTH:0]   trial;
  logic             ge;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    acc_nxt  = acc_r;
    m_nxt    = m_r;
    n_nxt    = n_r;
    trial    = {rem_r, dvd_r[WIDTH-1]};
    ge       = trial >= {1'b0, m_r};
    if (go) begin
      run_nxt = 1'b1;
      cnt_nxt = CW'(WIDTH);
      rem_nxt = '0;
      dvd_nxt = a;
      acc_nxt = '0;
      m_nxt   = m;
      n_nxt   = nxt;
    end else if (run_r) begin
      // restoring step: one quotient bit, product shifted and added
      rem_nxt = ge ? WIDTH'(trial - {1'b0, m_r}) : trial[WIDTH-1:0];
      dvd_nxt = {dvd_r[WIDTH-2:0], 1'b0};
      acc_nxt = {acc_r[WIDTH-2:0], 1'b0} + (ge ? n_r : '0);
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    acc_r <= acc_nxt;
    m_r   <= m_nxt;
    n_r   <= n_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;
  assign prod = acc_r;
endmodule

[tb/sv/testbench.sv]
// Testbench for the modular inverse unit: directed and random operands against a predictor.
`timescale 1ns / 1ps
module testbench;
  import minv_pkg::*;

  typedef struct packed {
    logic [INV_W-1:0] inverse;
    logic             found;
  } inv_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [IN_W-1:0]  in_value = '0;
  logic [IN_W-1:0]  in_modulus = '0;
  logic             out_valid;
  logic [INV_W-1:0] out_inverse;
  logic             out_found;

  logic             busy_s = 1'b1;
  inv_result_t      inv_expect_q[$];
  int unsigned      mismatches = 0;
  int unsigned      send_idle_pct = 0;

  modular_inverse_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_value    (in_value),
    .in_modulus  (in_modulus),
    .out_valid   (out_valid),
    .out_inverse (out_inverse),
    .out_found   (out_found)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Extended Euclid on magnitudes; coefficient signs alternate, so keep parity.
  function automatic inv_result_t predict_inverse(logic [63:0] v, logic [63:0] md);
    logic [63:0] a, m, modmag, cur, nxt, q, r, t;
    logic        odd;
    inv_result_t res;
    a = v[63] ? -v : v;
    m = md[63] ? -md : md;
    modmag = m;
    cur = 64'd1;
    nxt = 64'd0;
    odd = 1'b0;
    res = '0;
    if (a == 0 || m == 0 || m == 1) return res;
    while (a > 1) begin
      if (m == 0) return res;   // gcd above one
      q = a / m;
      r = a % m;
      a = m;
      m = r;
      t = cur + q * nxt;
      cur = nxt;
      nxt = t;
      odd = !odd;
    end
    res.inverse = (odd && cur != 0) ? INV_W'(modmag - cur) : INV_W'(cur);
    res.found = 1'b1;
    return res;
  endfunction

  always @(negedge clk) busy_s <= busy;

  always @(negedge clk) begin
    inv_result_t exp_r;
    if (rst_n && out_valid) begin
      if (inv_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: inverse=%h found=%b", out_inverse, out_found);
      end else begin
        exp_r = inv_expect_q.pop_front();
        if (out_inverse !== exp_r.inverse || out_found !== exp_r.found) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: inverse exp %h got %h, found exp %b got %b",
                     exp_r.inverse, out_inverse, exp_r.found, out_found);
        end
      end
    end
  end

  // One transfer: hold start until the unit is not busy at an edge.
  task automatic send_operands(logic [63:0] v, logic [63:0] md);
    in_value   <= v;
    in_modulus <= md;
    start      <= 1'b1;
    forever begin
      @(posedge clk);
      if (!busy_s) break;
    end
    inv_expect_q.push_back(predict_inverse(v, md));
    if ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (inv_expect_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] rand_operand();
    logic [63:0] w;
    int unsigned k;
    w = rand_word();
    case ($urandom_range(9))
      0, 1, 2, 3: ;
      4, 5, 6: begin
        k = $urandom_range(62, 2);
        w = w & ((64'd1 << k) - 1);
        if ($urandom_range(1)) w = -w;
      end
      7: w = {63'd0, 1'b1} << $urandom_range(63);
      8: w = 64'($urandom_range(40)) - 64'd20;
      default: w = {1'b1, 63'd0} + 64'($urandom_range(3));
    endcase
    return w;
  endfunction

  task automatic test_special_cases();
    send_operands(64'd0, 64'd7);
    send_operands(64'd5, 64'd0);
    send_operands(64'd0, 64'd0);
    send_operands(64'd5, 64'd1);
    send_operands(64'd5, -64'd1);
    send_operands(64'd6, 64'd9);
    send_operands(-64'd4, 64'd8);
    send_operands(64'd10, 64'd7);
    send_operands(64'd100, -64'd7);
    send_operands(-64'd3, 64'd7);
    send_operands(64'd1, 64'd2);
    send_operands(64'd12, 64'd13);
  endtask

  task automatic test_extremes();
    send_operands({1'b1, 63'd0}, 64'd3);
    send_operands(64'd3, {1'b1, 63'd0});
    send_operands({1'b1, 63'd0}, {1'b1, 63'd0});
    send_operands({1'b0, {63{1'b1}}}, {1'b1, 63'd0});
    send_operands({1'b1, 63'd0}, {1'b0, {63{1'b1}}});
    send_operands({64{1'b1}}, {1'b0, {63{1'b1}}});
    send_operands({1'b0, {63{1'b1}}} - 64'd1, {1'b0, {63{1'b1}}});
    send_operands(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAB);
    send_operands(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5557);
    send_operands(64'd12200160415121876738, 64'd7540113804746346429); // Fibonacci pair
  endtask

  task automatic test_random(int unsigned n, int unsigned idle_pct);
    send_idle_pct = idle_pct;
    repeat (n) send_operands(rand_operand(), rand_operand());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 0;
    test_special_cases();
    test_extremes();
    drain_results();
    test_random(385, 33);
    drain_results();
    test_random(385, 52);
    test_random(380, 0);
    drain_results();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && inv_expect_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("== FAIL ==");
    $finish;
  end
endmodule

[sim.f]
rtl/core/minv_pkg.sv
rtl/core/minv_div_step.sv
rtl/core/modular_inverse_unit.sv
tb/sv/testbench.sv
